// File: hdl/bfiq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bloom filter package
// This package holds the shared types and the MurmurHash3 constants for the
// Bloom filter insert and query unit.
// ----------------------------------------------------------------------------
package bfiq_pkg;

    localparam int KEY_W   = 64;
    localparam int LEN_W   = 4;
    localparam int SIZE_W  = 17;
    localparam int ROUND_W = 5;

    localparam logic [31:0] C1     = 32'hcc9e2d51;
    localparam logic [31:0] C2     = 32'h1b873593;
    localparam logic [31:0] F1     = 32'h85ebca6b;
    localparam logic [31:0] F2     = 32'hc2b2ae35;
    localparam logic [31:0] H_ADD  = 32'he6546b64;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // Register indexes of the configuration channel.
    localparam logic [0:0] REG_FILTER_SIZE = 1'b0;
    localparam logic [0:0] REG_HASH_ROUNDS = 1'b1;

    // One item as it travels from the front end to the back end.
    typedef struct packed {
        logic                op;
        logic [KEY_W-1:0]    key;
        logic [LEN_W-1:0]    len;
        logic [SIZE_W-1:0]   size;
        logic [ROUND_W-1:0]  rounds;
    } t_item;

endpackage

// File: hdl/bloom_filter_insert_query_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bloom filter insert and query unit
// Inserts keys into a Bloom filter and answers membership queries, using
// MurmurHash3 x86_32 with seeds 0 to hash_rounds-1.
// ----------------------------------------------------------------------------
// After reset the unit clears the filter word store one word at a time; the
// input queue takes up to two transactions in the meantime, but none is
// started until the clear is over. Configuration writes are taken at any
// time. Each hash round takes one step to start the hash, three per key block
// or partial tail (two of them at most), one to fold in the length, three for
// finalisation, one to set up the modulo, a bit-serial modulo by the filter
// size, one to hand the index over, and one each for the store read, the check
// or update and the step to the next round. An item also takes one step to
// take it from the queue and, for a query, one to place its answer, which waits
// while the result register is full. A query stops at the first clear bit.
// Insert transactions give no result; each query gives one result transaction
// on the output queue.
// A short queue on the input lets the next items wait while one is hashed.
module bloom_filter_insert_query_unit
    import bfiq_pkg::*;
#(
    parameter int FILTER_BITS   = 65536,
    parameter int MAX_HASHES    = 16,
    parameter int MAX_KEY_BYTES = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic               i_operation,
    input  logic [KEY_W-1:0]   i_key_bytes,
    input  logic [LEN_W-1:0]   i_key_length,
    output logic               empty,
    input  logic               pop,
    output logic               o_present,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [0:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    logic [SIZE_W-1:0]  r_size;
    logic [ROUND_W-1:0] r_rounds;
    logic               w_avail, w_take;
    t_item              w_item;

    assign o_cfg_ready = 1'b1;

    // Configuration registers; write these only while the unit is idle, which the unit itself does not enforce.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size   <= SIZE_W'(65536);
            r_rounds <= ROUND_W'(7);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_FILTER_SIZE: r_size   <= i_cfg_data[SIZE_W-1:0];
                REG_HASH_ROUNDS: r_rounds <= i_cfg_data[ROUND_W-1:0];
                default:         ;
            endcase
        end
    end

    bfiq_front #(
        .FILTER_BITS   (FILTER_BITS),
        .MAX_HASHES    (MAX_HASHES),
        .MAX_KEY_BYTES (MAX_KEY_BYTES),
        .DEPTH         (2)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (full),
        .i_op     (i_operation),
        .i_key    (i_key_bytes),
        .i_len    (i_key_length),
        .i_size   (r_size),
        .i_rounds (r_rounds),
        .i_take   (w_take),
        .o_avail  (w_avail),
        .o_item   (w_item)
    );

    bfiq_back #(
        .FILTER_BITS (FILTER_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_avail   (w_avail),
        .i_item    (w_item),
        .o_take    (w_take),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_present (o_present)
    );

endmodule

// File: hdl/bfiq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bloom filter front end
// Accepts items, clamps the key length and the configuration against the
// build limits, and writes the classified item into a short queue.
// ----------------------------------------------------------------------------
module bfiq_front
    import bfiq_pkg::*;
#(
    parameter int FILTER_BITS   = 65536,
    parameter int MAX_HASHES    = 16,
    parameter int MAX_KEY_BYTES = 8,
    parameter int DEPTH         = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic               i_op,
    input  logic [KEY_W-1:0]   i_key,
    input  logic [LEN_W-1:0]   i_len,
    input  logic [SIZE_W-1:0]  i_size,
    input  logic [ROUND_W-1:0] i_rounds,
    input  logic               i_take,
    output logic               o_avail,
    output t_item              o_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_item               r_q [DEPTH];
    logic [PTR_W-1:0]    r_wr, r_rd;
    logic [PTR_W:0]      r_cnt;
    t_item               w_item;
    logic                w_push, w_pop;

    always_comb begin
        w_item.op  = i_op;
        w_item.key = i_key;
        w_item.len = (i_len > LEN_W'(MAX_KEY_BYTES)) ? LEN_W'(MAX_KEY_BYTES) : i_len;
        if (i_size == '0) begin
            w_item.size = SIZE_W'(1);
        end else if (32'(i_size) > FILTER_BITS) begin
            w_item.size = SIZE_W'(FILTER_BITS);
        end else begin
            w_item.size = i_size;
        end
        w_item.rounds = (32'(i_rounds) > MAX_HASHES) ? ROUND_W'(MAX_HASHES) : i_rounds;
    end

    assign o_full  = (32'(r_cnt) == DEPTH);
    assign o_avail = (r_cnt != '0);
    assign o_item  = r_q[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_take && o_avail;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (32'(r_wr) == DEPTH - 1) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (32'(r_rd) == DEPTH - 1) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (PTR_W+1)'(w_push) - (PTR_W+1)'(w_pop);
        end
    end

endmodule

// File: hdl/bfiq_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MurmurHash3 x86_32 sequencer
// Computes one hash over a key of up to eight bytes, one multiply per cycle,
// then reduces it modulo the filter size by restoring subtraction.
// ----------------------------------------------------------------------------
module bfiq_hash
    import bfiq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [KEY_W-1:0]   i_key,
    input  logic [LEN_W-1:0]   i_len,
    input  logic [31:0]        i_seed,
    input  logic [SIZE_W-1:0]  i_size,
    output logic               o_done,
    output logic [SIZE_W-1:0]  o_index
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_KM1   = 10'b0000000010,
        S_KM2   = 10'b0000000100,
        S_HMIX  = 10'b0000001000,
        S_FIN0  = 10'b0000010000,
        S_FM1   = 10'b0000100000,
        S_FM2   = 10'b0001000000,
        S_FEND  = 10'b0010000000,
        S_MOD   = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } t_state;

    t_state       r_state, n_state;
    logic [31:0]  r_h, n_h;
    logic [31:0]  r_k, n_k;
    logic [1:0]   r_blk, n_blk;
    logic [5:0]   r_mbit, n_mbit;
    logic [SIZE_W-1:0] r_rem, n_rem;
    logic [KEY_W-1:0]  r_key;
    logic [LEN_W-1:0]  r_len;
    logic [SIZE_W-1:0] r_size;

    logic [1:0]   w_nblk;
    logic [1:0]   w_tail;
    logic [31:0]  w_word;
    logic [31:0]  w_mask;
    logic [SIZE_W:0] w_trial;

    assign w_nblk = 2'(r_len >> 2);
    assign w_tail = r_len[1:0];
    assign w_word = r_blk[0] ? r_key[63:32] : r_key[31:0];
    assign w_trial = {r_rem, r_h[31 - r_mbit[4:0]]};

    always_comb begin
        unique case (w_tail)
            2'd1:    w_mask = 32'h000000ff;
            2'd2:    w_mask = 32'h0000ffff;
            2'd3:    w_mask = 32'h00ffffff;
            default: w_mask = 32'hffffffff;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_h     = r_h;
        n_k     = r_k;
        n_blk   = r_blk;
        n_mbit  = r_mbit;
        n_rem   = r_rem;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_h     = i_seed;
                    n_blk   = '0;
                    n_state = S_HMIX;
                end
            end
            S_HMIX: begin
                // Pick the next block or the tail, or move to finalisation.
                if (r_blk < w_nblk || (r_blk == w_nblk && w_tail != 2'd0)) begin
                    n_k     = (r_blk < w_nblk ? w_word : (w_word & w_mask)) * C1;
                    n_state = S_KM1;
                end else begin
                    n_h     = r_h ^ 32'(r_len);
                    n_state = S_FIN0;
                end
            end
            S_KM1: begin
                n_k     = {r_k[16:0], r_k[31:17]} * C2;
                n_state = S_KM2;
            end
            S_KM2: begin
                n_h = r_h ^ r_k;
                if (r_blk < w_nblk) begin
                    n_h = {n_h[18:0], n_h[31:19]} * 32'd5 + H_ADD;
                end
                n_blk   = r_blk + 2'd1;
                n_state = S_HMIX;
            end
            S_FIN0: begin
                n_h     = (r_h ^ (r_h >> 16)) * F1;
                n_state = S_FM1;
            end
            S_FM1: begin
                n_h     = (r_h ^ (r_h >> 13)) * F2;
                n_state = S_FM2;
            end
            S_FM2: begin
                n_h     = r_h ^ (r_h >> 16);
                n_state = S_FEND;
            end
            S_FEND: begin
                n_rem   = '0;
                n_mbit  = '0;
                n_state = S_MOD;
            end
            S_MOD: begin
                if ({1'b0, w_trial} >= {1'b0, r_size}) begin
                    n_rem = SIZE_W'(w_trial - (SIZE_W+1)'(r_size));
                end else begin
                    n_rem = SIZE_W'(w_trial);
                end
                n_mbit = r_mbit + 6'd1;
                if (r_mbit == 6'd31) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h    <= n_h;
        r_k    <= n_k;
        r_blk  <= n_blk;
        r_mbit <= n_mbit;
        r_rem  <= n_rem;
        if (r_state == S_IDLE && i_start) begin
            r_key  <= i_key;
            r_len  <= i_len;
            r_size <= i_size;
        end
    end

    assign o_done  = (r_state == S_DONE);
    assign o_index = r_rem;

endmodule

// File: hdl/bfiq_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bloom filter back end
// Runs the hash rounds of one item, reads and updates the filter word store
// and places query answers in a one-entry result register.
// ----------------------------------------------------------------------------
module bfiq_back
    import bfiq_pkg::*;
#(
    parameter int FILTER_BITS = 65536
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_avail,
    input  t_item     i_item,
    output logic      o_take,
    output logic      o_empty,
    input  logic      i_pop,
    output logic      o_present
);

    localparam int WORDS  = (FILTER_BITS + 31) / 32;
    localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;

    typedef enum logic [7:0] {
        B_CLEAR = 8'b00000001,
        B_IDLE  = 8'b00000010,
        B_START = 8'b00000100,
        B_HASH  = 8'b00001000,
        B_READ  = 8'b00010000,
        B_CHECK = 8'b00100000,
        B_NEXT  = 8'b01000000,
        B_OUT   = 8'b10000000
    } t_bstate;

    t_bstate           r_state, n_state;
    t_item             r_item;
    logic [ROUND_W-1:0] r_round;
    logic [ADDR_W-1:0] r_clr;
    logic [ADDR_W-1:0] r_addr;
    logic [4:0]        r_bit;
    logic              r_ans;
    logic              r_full;
    logic              r_res;
    logic [31:0]       r_rdata;
    logic [31:0]       r_mem [WORDS];

    logic              w_hdone;
    logic [SIZE_W-1:0] w_idx;
    logic              w_start;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [31:0]       w_wdata;
    logic              w_hit;
    logic              w_in_range;

    bfiq_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_key   (r_item.key),
        .i_len   (r_item.len),
        .i_seed  (32'(r_round)),
        .i_size  (r_item.size),
        .o_done  (w_hdone),
        .o_index (w_idx)
    );

    assign w_start    = (r_state == B_START);
    assign w_hit      = r_rdata[r_bit];
    assign w_in_range = (32'(w_idx >> 5) < WORDS);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_CLEAR: if (32'(r_clr) == WORDS - 1) n_state = B_IDLE;
            B_IDLE: begin
                if (i_avail) begin
                    n_state = (i_item.rounds == '0) ?
                              ((i_item.op == OP_QUERY) ? B_OUT : B_IDLE) : B_START;
                end
            end
            B_START: n_state = B_HASH;
            B_HASH:  if (w_hdone) n_state = w_in_range ? B_READ : B_CHECK;
            B_READ:  n_state = B_CHECK;
            B_CHECK: begin
                if (r_item.op == OP_QUERY && !r_ans) begin
                    n_state = B_OUT;
                end else if (r_item.op == OP_QUERY && !w_hit) begin
                    n_state = B_OUT;
                end else begin
                    n_state = B_NEXT;
                end
            end
            B_NEXT: begin
                if (r_round == r_item.rounds) begin
                    n_state = (r_item.op == OP_QUERY) ? B_OUT : B_IDLE;
                end else begin
                    n_state = B_START;
                end
            end
            B_OUT:   if (!r_full) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    assign o_take = (r_state == B_IDLE) && i_avail;

    // An index past the store makes the query miss, as a clear bit would.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_addr;
        w_wdata = r_rdata | (32'd1 << r_bit);
        if (r_state == B_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr;
            w_wdata = '0;
        end else if (r_state == B_CHECK && r_item.op == OP_INSERT && r_ans) begin
            w_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (r_state == B_READ) begin
            r_rdata <= r_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_item <= i_item;
        end
        if (r_state == B_HASH && w_hdone) begin
            r_addr <= ADDR_W'(w_idx >> 5);
            r_bit  <= w_idx[4:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_CLEAR;
            r_clr   <= '0;
            r_round <= '0;
            r_ans   <= 1'b1;
            r_full  <= 1'b0;
            r_res   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (o_take) begin
                r_round <= '0;
                r_ans   <= 1'b1;
            end
            if (r_state == B_HASH && w_hdone) begin
                // Out-of-store index: mark the answer false, for a query or an insert alike.
                if (!w_in_range) begin
                    r_ans <= 1'b0;
                end
            end
            if (r_state == B_CHECK && r_item.op == OP_QUERY && !w_hit) begin
                r_ans <= 1'b0;
            end
            if (r_state == B_CHECK) begin
                r_round <= r_round + 1'b1;
            end
            if (r_full && i_pop) begin
                r_full <= 1'b0;
            end
            if (r_state == B_OUT && !r_full) begin
                r_full <= 1'b1;
                r_res  <= r_ans;
            end
        end
    end

    assign o_empty   = !r_full;
    assign o_present = r_res;

endmodule
